// File: hdl/lrubp_pkg.sv
// lrubp_pkg: shared constants of the buffer pool frame table
// opcodes, status codes, lru rank modes, field widths and default sizes; no dependencies
package lrubp_pkg;

  localparam int NUM_FRAMES_DEF      = 16;
  localparam int TEMP_FIFO_DEPTH_DEF = 16;
  localparam int PAGE_BITS_DEF       = 32;

  localparam int OP_W    = 3;
  localparam int TAB_W   = 8;
  localparam int PG_W    = 32;
  localparam int CFG_W   = 5;
  localparam int ST_W    = 2;
  localparam int FRM_W   = 4;
  localparam int IN_DW   = 48;
  localparam int OUT_DW  = 80;

  localparam logic [OP_W-1:0] OP_ACCESS   = 3'd0;
  localparam logic [OP_W-1:0] OP_PIN      = 3'd1;
  localparam logic [OP_W-1:0] OP_UNPIN    = 3'd2;
  localparam logic [OP_W-1:0] OP_RELEASE  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIRTY    = 3'd4;
  localparam logic [OP_W-1:0] OP_TEMP     = 3'd5;
  localparam logic [OP_W-1:0] OP_TEMP_PIN = 3'd6;

  localparam logic [ST_W-1:0] ST_HIT     = 2'd0;
  localparam logic [ST_W-1:0] ST_PLACED  = 2'd1;
  localparam logic [ST_W-1:0] ST_NOFRAME = 2'd2;
  localparam logic [ST_W-1:0] ST_ABSENT  = 2'd3;

  // lru rank update modes
  localparam logic [2:0] M_KEEP  = 3'd0;
  localparam logic [2:0] M_ZERO  = 3'd1;
  localparam logic [2:0] M_TAKE  = 3'd2;
  localparam logic [2:0] M_FRONT = 3'd3;
  localparam logic [2:0] M_TOUCH = 3'd4;

  typedef logic [2:0] lru_mode_t;

endpackage

// File: hdl/lru_buffer_pool_pin_table.sv
// lru_buffer_pool_pin_table: frame table of a page buffer pool with lru and pinning
// depends on lrubp_pkg; tags and the temp number fifo live in memories with a registered read
// an item passes setup, a scan of the tag memory (one read per frame) and the
// single update cycle, which waits while the output register still holds a result;
// a new item is taken only once the previous one has left the update cycle
// a new item is taken while the previous result still waits in the output register
// reset: synchronous active low; clears valid, pin, dirty, ranks, fifo count,
// temp counter and sets frames_in_use to 16; tag and fifo memories are not cleared
module lru_buffer_pool_pin_table #(
  parameter int NUM_FRAMES      = lrubp_pkg::NUM_FRAMES_DEF,
  parameter int TEMP_FIFO_DEPTH = lrubp_pkg::TEMP_FIFO_DEPTH_DEF,
  parameter int PAGE_BITS       = lrubp_pkg::PAGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lrubp_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // op [2:0], table_id [10:3], page_num [42:11], zero [47:43]
  input  logic [lrubp_pkg::IN_DW-1:0] in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // status [1:0], frame [5:2], page_out [37:6], load_needed [38],
  // evict_dirty [39], evict_table [47:40], evict_page [79:48]
  output logic [lrubp_pkg::OUT_DW-1:0] out_tdata
);
  import lrubp_pkg::*;

  localparam int FW  = $clog2(NUM_FRAMES);
  localparam int SW  = FW + 1;
  localparam int LW  = (FW + 1 > CFG_W) ? FW + 1 : CFG_W;
  localparam int AW  = (TEMP_FIFO_DEPTH > 1) ? $clog2(TEMP_FIFO_DEPTH) : 1;
  localparam int CW  = $clog2(TEMP_FIFO_DEPTH + 1);
  localparam int TW  = TAB_W + PAGE_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;

  logic [2:0] state_r, state_nxt;

  // latched item
  logic [OP_W-1:0]      op_r;
  logic [TAB_W-1:0]     tab_r;
  logic [PAGE_BITS-1:0] pg_r;
  // search key (temp number resolved)
  logic [TAB_W-1:0]     key_tab_r;
  logic [PAGE_BITS-1:0] key_page_r;

  logic [CFG_W-1:0] cfg_r;

  // frame state in flops
  logic [NUM_FRAMES-1:0] valid_r, valid_nxt;
  logic [NUM_FRAMES-1:0] pinned_r, pinned_nxt;
  logic [NUM_FRAMES-1:0] dirty_r, dirty_nxt;
  logic [FW-1:0]         rank_r   [NUM_FRAMES];
  logic [FW-1:0]         rank_nxt [NUM_FRAMES];

  // tag memory
  logic [TW-1:0] tag_mem [NUM_FRAMES];
  logic [TW-1:0] tag_q;
  logic          tag_we;
  logic [FW-1:0] tag_wa;

  // temp number fifo (circular)
  logic [PAGE_BITS-1:0] fifo_mem [TEMP_FIFO_DEPTH];
  logic [PAGE_BITS-1:0] fifo_q;
  logic [AW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 push, pop;
  logic [AW:0]          tail_sum;
  logic [AW-1:0]        tail;
  logic [PAGE_BITS-1:0] next_temp_r, next_temp_nxt;

  // scan
  logic [SW-1:0] scan_r;
  logic [FW-1:0] cmp_idx_r;
  logic          cmp_vld_r;
  logic          hit_r;
  logic [FW-1:0] hit_idx_r;
  logic          vf_r;
  logic [FW-1:0] vict_r;
  logic [TW-1:0] vict_tag_r;

  // output register
  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r;

  logic in_acc, exec_go;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign exec_go    = (state_r == S_EXEC) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // lowest free frame below the saturated frames_in_use
  logic [LW-1:0] lim;
  logic          free_found;
  logic [FW-1:0] free_idx;
  always_comb begin
    if (cfg_r == '0) lim = LW'(1);
    else if (LW'(cfg_r) > LW'(NUM_FRAMES)) lim = LW'(NUM_FRAMES);
    else lim = LW'(cfg_r);
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (!free_found && !valid_r[i] && (LW'(i) < lim)) begin
        free_found = 1'b1;
        free_idx   = FW'(i);
      end
    end
  end

  // update cycle
  logic                 is_temp, pin_req, fok;
  lru_mode_t            mode;
  logic [FW-1:0]        lf, fsel;
  logic [FW-1:0]        rf;
  logic [ST_W-1:0]      st;
  logic [PAGE_BITS-1:0] pout;
  logic                 load, ev;
  logic [TW-1:0]        ev_tag;

  always_comb begin
    is_temp  = (op_r == OP_TEMP) || (op_r == OP_TEMP_PIN);
    pin_req  = (op_r == OP_PIN) || (op_r == OP_TEMP_PIN);
    valid_nxt  = valid_r;
    pinned_nxt = pinned_r;
    dirty_nxt  = dirty_r;
    mode   = M_KEEP;
    lf     = hit_idx_r;
    fsel   = hit_idx_r;
    fok    = 1'b0;
    st     = ST_HIT;
    pout   = key_page_r;
    load   = 1'b0;
    ev     = 1'b0;
    ev_tag = '0;
    tag_we = 1'b0;
    tag_wa = hit_idx_r;
    push   = 1'b0;
    pop    = 1'b0;
    next_temp_nxt = next_temp_r;
    case (op_r)
      OP_ACCESS, OP_PIN, OP_TEMP, OP_TEMP_PIN: begin
        if (hit_r) begin
          fok = 1'b1;
          if (!pinned_r[hit_idx_r]) begin
            if (pin_req) begin
              mode = M_TAKE;
              pinned_nxt[hit_idx_r] = 1'b1;
            end else begin
              mode = M_TOUCH;
            end
          end
        end else if (free_found || vf_r) begin
          fok  = 1'b1;
          st   = ST_PLACED;
          load = !is_temp;
          if (free_found) begin
            fsel = free_idx;
            mode = pin_req ? M_ZERO : M_FRONT;
          end else begin
            fsel = vict_r;
            mode = pin_req ? M_TAKE : M_TOUCH;
            if (dirty_r[vict_r]) begin
              ev     = 1'b1;
              ev_tag = vict_tag_r;
            end
          end
          lf     = fsel;
          tag_we = 1'b1;
          tag_wa = fsel;
          valid_nxt[fsel]  = 1'b1;
          pinned_nxt[fsel] = pin_req;
          dirty_nxt[fsel]  = 1'b0;
        end else begin
          st = ST_NOFRAME;
          if (is_temp) pout = '0;
        end
        // consume the temp number once a frame holds it
        if (is_temp && fok) begin
          if (cnt_r != '0) pop = 1'b1;
          else next_temp_nxt = next_temp_r + PAGE_BITS'(1);
        end
      end
      OP_UNPIN: begin
        if (!hit_r) st = ST_ABSENT;
        else if (pinned_r[hit_idx_r]) begin
          pinned_nxt[hit_idx_r] = 1'b0;
          mode = M_FRONT;
        end
      end
      OP_RELEASE: begin
        if (tab_r == '0) begin
          // temp number goes back to the fifo, dropped when full
          push = (cnt_r < CW'(TEMP_FIFO_DEPTH));
          if (hit_r) begin
            if (!pinned_r[hit_idx_r]) mode = M_TAKE;
            valid_nxt[hit_idx_r]  = 1'b0;
            pinned_nxt[hit_idx_r] = 1'b0;
            dirty_nxt[hit_idx_r]  = 1'b0;
          end else begin
            st = ST_ABSENT;
          end
        end else if (!hit_r) begin
          st = ST_ABSENT;
        end else if (pinned_r[hit_idx_r]) begin
          pinned_nxt[hit_idx_r] = 1'b0;
          mode = M_FRONT;
        end else begin
          if (dirty_r[hit_idx_r]) begin
            ev     = 1'b1;
            ev_tag = {key_tab_r, key_page_r};
          end
          mode = M_TAKE;
          valid_nxt[hit_idx_r]  = 1'b0;
          dirty_nxt[hit_idx_r]  = 1'b0;
        end
      end
      OP_DIRTY: begin
        if (hit_r) dirty_nxt[hit_idx_r] = 1'b1;
        else st = ST_ABSENT;
      end
      default: begin
        st = ST_ABSENT;
      end
    endcase

    // rank update, each frame on its own
    rf = rank_r[lf];
    for (int i = 0; i < NUM_FRAMES; i++) begin
      rank_nxt[i] = rank_r[i];
      if ((FW'(i) != lf) && valid_r[i] && !pinned_r[i]) begin
        case (mode)
          M_TAKE:  if (rank_r[i] > rf) rank_nxt[i] = rank_r[i] - FW'(1);
          M_FRONT: rank_nxt[i] = rank_r[i] + FW'(1);
          M_TOUCH: if (rank_r[i] < rf) rank_nxt[i] = rank_r[i] + FW'(1);
          default: rank_nxt[i] = rank_r[i];
        endcase
      end
    end
    if (mode != M_KEEP) rank_nxt[lf] = '0;
  end

  // fifo pointers
  always_comb begin
    tail_sum = {1'b0, head_r} + (AW + 1)'(cnt_r);
    if (tail_sum >= (AW + 1)'(TEMP_FIFO_DEPTH))
      tail = AW'(tail_sum - (AW + 1)'(TEMP_FIFO_DEPTH));
    else
      tail = AW'(tail_sum);
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (pop) begin
      head_nxt = (head_r == AW'(TEMP_FIFO_DEPTH - 1)) ? '0 : head_r + AW'(1);
      cnt_nxt  = cnt_r - CW'(1);
    end else if (push) begin
      cnt_nxt  = cnt_r + CW'(1);
    end
  end

  // state sequencing
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_SETUP;
      S_SETUP: state_nxt = S_SCAN;
      S_SCAN:  if ((scan_r == SW'(NUM_FRAMES)) && !cmp_vld_r) state_nxt = S_EXEC;
      S_EXEC:  if (exec_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (tag_we && exec_go) tag_mem[tag_wa] <= {key_tab_r, key_page_r};
    tag_q <= tag_mem[scan_r[FW-1:0]];
    if (push && exec_go) fifo_mem[tail] <= pg_r;
    fifo_q <= fifo_mem[head_r];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tdata[2:0];
      tab_r <= in_tdata[10:3];
      pg_r  <= PAGE_BITS'(in_tdata[42:11]);
    end
    if (state_r == S_SETUP) begin
      if ((op_r == OP_TEMP) || (op_r == OP_TEMP_PIN)) begin
        key_tab_r  <= '0;
        key_page_r <= (cnt_r != '0) ? fifo_q : next_temp_r;
      end else begin
        key_tab_r  <= tab_r;
        key_page_r <= pg_r;
      end
    end
    if (state_r == S_SCAN && !(scan_r == SW'(NUM_FRAMES))) cmp_idx_r <= scan_r[FW-1:0];
    if (state_r == S_SCAN && cmp_vld_r) begin
      if (!hit_r && valid_r[cmp_idx_r] && (tag_q == {key_tab_r, key_page_r}))
        hit_idx_r <= cmp_idx_r;
      if (valid_r[cmp_idx_r] && !pinned_r[cmp_idx_r] &&
          (!vf_r || (rank_r[cmp_idx_r] > rank_r[vict_r]))) begin
        vict_r     <= cmp_idx_r;
        vict_tag_r <= tag_q;
      end
    end
    if (exec_go) begin
      out_data_r <= {32'(ev_tag[PAGE_BITS-1:0]), ev_tag[TW-1:PAGE_BITS], ev, load,
                     32'(pout), (st <= ST_PLACED) ? FRM_W'(fsel) : FRM_W'(0), st};
    end
    if (!rst_n) begin
      for (int i = 0; i < NUM_FRAMES; i++) rank_r[i] <= '0;
    end else if (exec_go) begin
      for (int i = 0; i < NUM_FRAMES; i++) rank_r[i] <= rank_nxt[i];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= CFG_W'(16);
      valid_r     <= '0;
      pinned_r    <= '0;
      dirty_r     <= '0;
      head_r      <= '0;
      cnt_r       <= '0;
      next_temp_r <= '0;
      scan_r      <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      vf_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cfg_r <= cfg_wdata;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_SETUP: begin
          scan_r    <= '0;
          cmp_vld_r <= 1'b0;
          hit_r     <= 1'b0;
          vf_r      <= 1'b0;
        end
        S_SCAN: begin
          if (scan_r != SW'(NUM_FRAMES)) begin
            scan_r    <= scan_r + SW'(1);
            cmp_vld_r <= 1'b1;
          end else begin
            cmp_vld_r <= 1'b0;
          end
          if (cmp_vld_r) begin
            if (valid_r[cmp_idx_r] && (tag_q == {key_tab_r, key_page_r})) hit_r <= 1'b1;
            if (valid_r[cmp_idx_r] && !pinned_r[cmp_idx_r]) vf_r <= 1'b1;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            valid_r     <= valid_nxt;
            pinned_r    <= pinned_nxt;
            dirty_r     <= dirty_nxt;
            head_r      <= head_nxt;
            cnt_r       <= cnt_nxt;
            next_temp_r <= next_temp_nxt;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // a result appears only from the update cycle
  a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result without update cycle");

  // a pinned frame is always resident
  a_pin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (pinned_r & ~valid_r) == '0)
    else $error("pinned frame not valid");

  // fifo fill never beyond its depth
  a_fifo_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TEMP_FIFO_DEPTH))
    else $error("fifo count overflow");

  // frame valid bits and fifo count change only in the update cycle
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_EXEC) |=> $stable(valid_r) && $stable(cnt_r))
    else $error("frame state changed outside update");

endmodule
